// ===== rtl/khp_pkg.sv =====
// Shared constants, types and pointer helpers for the keyed handle pool cache.
`default_nettype none

package khp_pkg;

   localparam int CAPACITY = 16;
   localparam int SLOTS    = CAPACITY + 1;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int SUM_W    = $clog2(2 * SLOTS);
   localparam int MAXE_W   = 5;
   localparam int CMP_W    = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 16;
   localparam int DROP_W   = 5;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 24;

   localparam logic [MAXE_W-1:0] MAXE_RESET = MAXE_W'(16);

   localparam logic ACT_TAKE = 1'b0;
   localparam logic ACT_PUT  = 1'b1;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
   } khp_entry_type;

   typedef struct packed {
      logic                action;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } khp_req_type;

   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] found_handle;
      logic [DROP_W-1:0]   dropped_count;
   } khp_res_type;

   function automatic logic [IDX_W-1:0] khp_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] khp_wrap(input logic [SUM_W-1:0] s);
      return (s >= SUM_W'(SLOTS)) ? IDX_W'(s - SUM_W'(SLOTS)) : IDX_W'(s);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/khp_engine.sv =====
// Ring-buffer entry RAM with the search, gap-close and eviction sequencer.
`default_nettype none

module khp_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire khp_pkg::khp_req_type          req,
   input  wire logic [khp_pkg::MAXE_W-1:0]    max_entries,
   input  wire logic                          out_free,
   output logic                               ready,
   output logic                               done,
   output khp_pkg::khp_res_type               res
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_DONE   = 4'b1000
   } khp_state_type;

   khp_state_type                   state_ff, state_in;
   logic [khp_pkg::IDX_W-1:0]       head_ff, head_in;
   logic [khp_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [khp_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [khp_pkg::IDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [khp_pkg::IDX_W-1:0]       rd_addr_ff, rd_addr_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic [khp_pkg::IDX_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [khp_pkg::KEY_W-1:0]       key_ff, key_in;
   khp_pkg::khp_res_type            res_ff, res_in;

   khp_pkg::khp_entry_type          mem [khp_pkg::SLOTS];
   khp_pkg::khp_entry_type          rdata_ff;
   khp_pkg::khp_entry_type          wdata;
   logic [khp_pkg::IDX_W-1:0]       waddr;
   logic                            mem_we;

   logic [khp_pkg::CMP_W-1:0]       lim;
   logic [khp_pkg::CMP_W-1:0]       cnt1;
   logic [khp_pkg::CMP_W-1:0]       ndrop;
   logic [khp_pkg::IDX_W-1:0]       tail;
   logic                            match;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[rd_ptr_ff];
   end

   always_comb begin
      lim = (khp_pkg::CMP_W'(max_entries) > khp_pkg::CMP_W'(khp_pkg::CAPACITY)) ?
            khp_pkg::CMP_W'(khp_pkg::CAPACITY) : khp_pkg::CMP_W'(max_entries);
      cnt1  = khp_pkg::CMP_W'(count_ff) + 1'b1;
      ndrop = (cnt1 > lim) ? cnt1 - lim : '0;
      tail  = khp_pkg::khp_wrap(khp_pkg::SUM_W'(head_ff) + khp_pkg::SUM_W'(count_ff));
      match = rd_valid_ff && (rdata_ff.key == key_ff);
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      cnt_in      = cnt_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_addr_in  = rd_addr_ff;
      rd_valid_in = 1'b0;
      wr_ptr_in   = wr_ptr_ff;
      key_in      = key_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      waddr       = wr_ptr_ff;
      wdata       = rdata_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req.key;
               res_in = '0;
               if (req.action == khp_pkg::ACT_PUT) begin
                  mem_we       = 1'b1;
                  waddr        = tail;
                  wdata.key    = req.key;
                  wdata.handle = req.handle;
                  count_in     = khp_pkg::CNT_W'(cnt1 - ndrop);
                  head_in      = khp_pkg::khp_wrap(khp_pkg::SUM_W'(head_ff) +
                                                   khp_pkg::SUM_W'(ndrop));
                  res_in.dropped_count = ndrop[khp_pkg::DROP_W-1:0];
                  state_in     = ST_DONE;
               end else begin
                  rd_ptr_in = head_ff;
                  cnt_in    = '0;
                  state_in  = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (match) begin
               res_in.hit          = 1'b1;
               res_in.found_handle = rdata_ff.handle;
               wr_ptr_in           = rd_addr_ff;
               cnt_in              = count_ff - cnt_ff;
               state_in            = ST_SHIFT;
            end else if (cnt_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_addr_in  = rd_ptr_ff;
               rd_ptr_in   = khp_pkg::khp_inc(rd_ptr_ff);
               cnt_in      = cnt_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (rd_valid_ff) begin
               mem_we    = 1'b1;
               wr_ptr_in = khp_pkg::khp_inc(wr_ptr_ff);
            end
            if (cnt_ff != '0) begin
               rd_valid_in = 1'b1;
               rd_addr_in  = rd_ptr_ff;
               rd_ptr_in   = khp_pkg::khp_inc(rd_ptr_ff);
               cnt_in      = cnt_ff - 1'b1;
            end else if (!rd_valid_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      rd_ptr_ff  <= rd_ptr_in;
      rd_addr_ff <= rd_addr_in;
      wr_ptr_ff  <= wr_ptr_in;
      key_ff     <= key_in;
      res_ff     <= res_in;
   end

   assign ready = (state_ff == ST_IDLE);
   assign done  = (state_ff == ST_DONE);
   assign res   = res_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= khp_pkg::CNT_W'(khp_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= khp_pkg::IDX_W'(khp_pkg::SLOTS - 1))
      else $error("head pointer outside ring");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (cnt_ff <= count_ff))
      else $error("scan index past entry count");

   a_copy_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rd_valid_ff && cnt_ff != '0) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("gap close write collides with read");

   a_put_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req.action == khp_pkg::ACT_PUT) |=>
      (khp_pkg::CMP_W'(count_ff) <= $past(lim)))
      else $error("put left more entries than the limit");

endmodule

`default_nettype wire

// ===== rtl/keyed_handle_pool_cache_core.sv =====
// Top level of the keyed handle pool cache: stream ports, limit register, result register.
//
//   channel  dir  handshake          payload
//   req      in   req_tvalid/tready  tuser action, tdata key/handle
//   rsp      out  rsp_tvalid/tready  tdata hit/found_handle/dropped_count
//   csr      in   csr_wen            csr_wdata max_entries
//
// A put writes its entry and hands its result through the engine to the output register;
// the engine turns idle, ready for the next request, as the result enters that register.
// A take scans the entry RAM and closes the gap one entry per cycle through its single
// read port before its result is shown. One request is in work at a time.
// Reset empties the pool and sets max_entries to 16; no clearing pass is needed.
// A stalled result holds in the output register; the next request is taken meanwhile and
// its result waits in the engine, with req_tready low, until the register frees.
`default_nettype none

module keyed_handle_pool_cache_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [khp_pkg::REQ_W-1:0]     req_tdata,  // key[31:0], handle[47:32]
   input  wire logic                          req_tuser,  // action
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [khp_pkg::RSP_W-1:0]          rsp_tdata,  // hit[0], found_handle[16:1],
                                                          // dropped_count[21:17], zero
   input  wire logic                          csr_wen,
   input  wire logic [khp_pkg::MAXE_W-1:0]    csr_wdata
);

   logic [khp_pkg::MAXE_W-1:0] max_entries_ff, max_entries_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   khp_pkg::khp_res_type       rsp_res_ff, rsp_res_in;
   khp_pkg::khp_req_type       req;
   khp_pkg::khp_res_type       res;
   logic                       start;
   logic                       ready;
   logic                       done;
   logic                       out_free;

   assign req.action = req_tuser;
   assign req.key    = req_tdata[khp_pkg::KEY_W-1:0];
   assign req.handle = req_tdata[khp_pkg::KEY_W +: khp_pkg::HANDLE_W];

   assign req_tready = ready && !reset;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   khp_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .max_entries (max_entries_ff),
      .out_free    (out_free),
      .ready       (ready),
      .done        (done),
      .res         (res)
   );

   always_comb begin
      max_entries_in = csr_wen ? csr_wdata : max_entries_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_res_in     = rsp_res_ff;
      if (done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= khp_pkg::MAXE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_entries_ff <= max_entries_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = khp_pkg::RSP_W'({rsp_res_ff.dropped_count,
                                        rsp_res_ff.found_handle,
                                        rsp_res_ff.hit});

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the keyed handle pool cache core: directed table, random phases.
`timescale 1ns / 100ps

module tb_top;

   localparam int NUM_ROWS     = 24;
   localparam int RANDOM_ITEMS = 1030;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = khp_pkg::CAPACITY + 10;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      logic                         action;
      logic [khp_pkg::KEY_W-1:0]    key;
      logic [khp_pkg::HANDLE_W-1:0] handle;
      logic                         typed;
      logic                         e_hit;
      logic [khp_pkg::HANDLE_W-1:0] e_handle;
      logic [khp_pkg::DROP_W-1:0]   e_drop;
      logic [khp_pkg::MAXE_W-1:0]   limit;
   } stim_row_type;

   localparam stim_row_type STIM_TABLE [NUM_ROWS] = '{
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0000, 16'h0001, 1'b1, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0000, 16'h1234, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0005, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h0000_0005, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'hAAAA_5555, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_CFG, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h1234_5678, 16'h00FF, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h1234_5678, 16'h0000, 1'b1, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_CFG, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd31},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0001, 16'h0001, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0002, 16'h0002, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0001, 16'h0003, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0003, 16'h0004, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_CFG, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd1},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h0000_0002, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_PUT,  32'h0000_0004, 16'h0005, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_REQ, khp_pkg::ACT_TAKE, 32'h0000_0004, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd0},
      '{ROW_CFG, khp_pkg::ACT_TAKE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 5'd0, 5'd16}
   };

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [khp_pkg::REQ_W-1:0]    req_tdata  = '0;
   logic                         req_tuser  = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [khp_pkg::RSP_W-1:0]    rsp_tdata;
   logic                         csr_wen    = 1'b0;
   logic [khp_pkg::MAXE_W-1:0]   csr_wdata  = '0;

   logic [khp_pkg::KEY_W-1:0]    pool_keys    [khp_pkg::SLOTS];
   logic [khp_pkg::HANDLE_W-1:0] pool_handles [khp_pkg::SLOTS];
   int                           pool_count = 0;
   logic [khp_pkg::MAXE_W-1:0]   pool_limit = khp_pkg::MAXE_RESET;
   khp_pkg::khp_res_type         pending_results [$];

   int err_count    = 0;
   int req_sent     = 0;
   int take_hits    = 0;
   int take_misses  = 0;
   int puts         = 0;
   int evicted      = 0;
   int limit_writes = 0;
   int idle_cycles  = 0;

   keyed_handle_pool_cache_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic khp_pkg::khp_res_type pool_apply(
         input logic                         action,
         input logic [khp_pkg::KEY_W-1:0]    key,
         input logic [khp_pkg::HANDLE_W-1:0] handle);
      khp_pkg::khp_res_type res;
      int                   lim;
      int                   n;
      res = '0;
      if (action == khp_pkg::ACT_TAKE) begin
         for (int i = 0; i < pool_count; i++) begin
            if (pool_keys[i] == key) begin
               res.hit          = 1'b1;
               res.found_handle = pool_handles[i];
               for (int j = i; j < pool_count - 1; j++) begin
                  pool_keys[j]    = pool_keys[j + 1];
                  pool_handles[j] = pool_handles[j + 1];
               end
               pool_count--;
               break;
            end
         end
         if (res.hit) take_hits++;
         else take_misses++;
      end else begin
         lim = (int'(pool_limit) > khp_pkg::CAPACITY) ? khp_pkg::CAPACITY : int'(pool_limit);
         pool_keys[pool_count]    = key;
         pool_handles[pool_count] = handle;
         pool_count++;
         if (pool_count > lim) begin
            n = pool_count - lim;
            for (int i = 0; i < lim; i++) begin
               pool_keys[i]    = pool_keys[i + n];
               pool_handles[i] = pool_handles[i + n];
            end
            pool_count        = lim;
            res.dropped_count = khp_pkg::DROP_W'(n);
            evicted += n;
         end
         puts++;
      end
      return res;
   endfunction

   task automatic send_req(input logic action, input logic [khp_pkg::KEY_W-1:0] key,
                           input logic [khp_pkg::HANDLE_W-1:0] handle, input logic typed,
                           input khp_pkg::khp_res_type typed_res);
      int                   gap;
      khp_pkg::khp_res_type predicted;
      gap = (req_sent % 100 < 25) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {handle, key};
      do @(posedge clock); while (!req_tready);
      predicted = pool_apply(action, key, handle);
      pending_results = {pending_results, (typed ? typed_res : predicted)};
      req_sent++;
   endtask

   task automatic write_limit(input logic [khp_pkg::MAXE_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen    <= 1'b0;
      pool_limit = value;
      limit_writes++;
      @(posedge clock);
   endtask

   initial begin
      khp_pkg::khp_res_type       typed_res;
      logic [khp_pkg::KEY_W-1:0]  key_set [6];
      logic [khp_pkg::KEY_W-1:0]  key;
      logic [khp_pkg::MAXE_W-1:0] lim;
      logic                       action;
      int                         base;
      int                         phase_len;
      int                         put_pct;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (STIM_TABLE[r].kind == ROW_CFG) begin
            write_limit(STIM_TABLE[r].limit);
         end else begin
            typed_res.hit           = STIM_TABLE[r].e_hit;
            typed_res.found_handle  = STIM_TABLE[r].e_handle;
            typed_res.dropped_count = STIM_TABLE[r].e_drop;
            send_req(STIM_TABLE[r].action, STIM_TABLE[r].key, STIM_TABLE[r].handle,
                     STIM_TABLE[r].typed, typed_res);
         end
      end
      base = req_sent;
      while (req_sent - base < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               lim = '0;
            end
            1: begin
               lim = khp_pkg::MAXE_W'($urandom_range(khp_pkg::CAPACITY + 1, 31));
            end
            2: begin
               lim = khp_pkg::MAXE_W'(khp_pkg::CAPACITY);
            end
            default: begin
               lim = khp_pkg::MAXE_W'($urandom_range(1, khp_pkg::CAPACITY));
            end
         endcase
         write_limit(lim);
         foreach (key_set[k]) key_set[k] = $urandom;
         phase_len = $urandom_range(60, 100);
         if (phase_len > RANDOM_ITEMS - (req_sent - base)) begin
            phase_len = RANDOM_ITEMS - (req_sent - base);
         end
         put_pct   = $urandom_range(40, 70);
         repeat (phase_len) begin
            action = ($urandom_range(0, 99) < put_pct) ? khp_pkg::ACT_PUT : khp_pkg::ACT_TAKE;
            key    = ($urandom_range(0, 9) == 0) ? $urandom : key_set[$urandom_range(0, 5)];
            send_req(action, key, khp_pkg::HANDLE_W'($urandom_range(1, 65535)), 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d puts, %0d take hits, %0d take misses, %0d evictions",
               req_sent, puts, take_hits, take_misses, evicted);
      $display("over %0d limit settings, with long result stalls; %0d mismatches",
               limit_writes, err_count);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT || taken == 3 * HOLD_AT) stall = HOLD_CYCLES;
         else if (taken % 128 < 32) stall = 0;
         else stall = $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   always @(posedge clock) begin
      khp_pkg::khp_res_type got;
      khp_pkg::khp_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit           = rsp_tdata[0];
         got.found_handle  = rsp_tdata[16:1];
         got.dropped_count = rsp_tdata[21:17];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer: hit %0d handle %h dropped %0d",
                     $time, got.hit, got.found_handle, got.dropped_count);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
               err_count++;
            end
            if (got.found_handle !== want.found_handle) begin
               $display("%0t: found_handle expected %h actual %h",
                        $time, want.found_handle, got.found_handle);
               err_count++;
            end
            if (got.dropped_count !== want.dropped_count) begin
               $display("%0t: dropped_count expected %0d actual %0d",
                        $time, want.dropped_count, got.dropped_count);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
rtl/khp_pkg.sv
rtl/khp_engine.sv
rtl/keyed_handle_pool_cache_core.sv
verif/tb_top.sv
